// File: hdl/dsts_pkg.sv
// Package: shared constants, microcode types and the control program of the time switch.
`default_nettype none
package dsts_pkg;

  // Schedule geometry
  localparam int SECTIONS = 3;
  localparam int HOURS    = 24;
  localparam int HOUR_W   = (HOURS > 1) ? $clog2(HOURS) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int SEC_W   = 2;
  localparam int HR_W    = 5;
  localparam int LIT_W   = 3;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;

  // Step counter
  localparam int PC_W = 4;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_UNIQUE = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  // Per-section schedule command
  typedef enum logic [1:0] {
    SCH_NONE  = 2'd0,
    SCH_ON    = 2'd1,
    SCH_OFF   = 2'd2,
    SCH_SPARE = 2'd3
  } sch_t;

  typedef logic [SECTIONS-1:0][1:0] sch_row_t;

  // Datapath actions of one control word
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_H_ZERO,
    ACT_CLEAR,
    ACT_WRITE_ON,
    ACT_WRITE_OFF,
    ACT_SCAN_INIT,
    ACT_SCAN_STEP,
    ACT_HOUR_ADV,
    ACT_APPLY,
    ACT_EMIT
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_IN,
    CND_TICK,
    CND_REJECT,
    CND_FREE,
    CND_H_MORE,
    CND_SCAN_GO,
    CND_HIT,
    CND_OUT_BUSY
  } cnd_t;

  typedef struct packed {
    act_t            act;
    cnd_t            cnd;
    logic [PC_W-1:0] target;
  } dsts_uword_t;

  // Status flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic reject;
    logic is_free;
    logic h_more;
    logic scan_go;
    logic hit;
    logic out_busy;
  } dsts_flags_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
  localparam logic [PC_W-1:0] PC_CLEAR = 4'd5;
  localparam logic [PC_W-1:0] PC_WON   = 4'd6;
  localparam logic [PC_W-1:0] PC_SCAN  = 4'd8;
  localparam logic [PC_W-1:0] PC_SLOOP = 4'd9;
  localparam logic [PC_W-1:0] PC_TICK  = 4'd12;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd15;

  // Control program; a step that does not jump falls through to the next
  function automatic dsts_uword_t dsts_rom(input logic [PC_W-1:0] pc);
    dsts_uword_t w;
    w = '{act: ACT_NOP, cnd: CND_NEVER, target: PC_FETCH};
    case (pc)
      4'd0:  w = '{act: ACT_ACCEPT,    cnd: CND_NO_IN,    target: PC_FETCH};
      4'd1:  w = '{act: ACT_NOP,       cnd: CND_TICK,     target: PC_TICK};
      4'd2:  w = '{act: ACT_NOP,       cnd: CND_REJECT,   target: PC_EMIT};
      4'd3:  w = '{act: ACT_NOP,       cnd: CND_FREE,     target: PC_SCAN};
      4'd4:  w = '{act: ACT_H_ZERO,    cnd: CND_NEVER,    target: PC_FETCH};
      4'd5:  w = '{act: ACT_CLEAR,     cnd: CND_H_MORE,   target: PC_CLEAR};
      4'd6:  w = '{act: ACT_WRITE_ON,  cnd: CND_NEVER,    target: PC_FETCH};
      4'd7:  w = '{act: ACT_WRITE_OFF, cnd: CND_ALWAYS,   target: PC_EMIT};
      4'd8:  w = '{act: ACT_SCAN_INIT, cnd: CND_NEVER,    target: PC_FETCH};
      4'd9:  w = '{act: ACT_SCAN_STEP, cnd: CND_SCAN_GO,  target: PC_SLOOP};
      4'd10: w = '{act: ACT_NOP,       cnd: CND_HIT,      target: PC_EMIT};
      4'd11: w = '{act: ACT_NOP,       cnd: CND_ALWAYS,   target: PC_WON};
      4'd12: w = '{act: ACT_HOUR_ADV,  cnd: CND_NEVER,    target: PC_FETCH};
      4'd13: w = '{act: ACT_APPLY,     cnd: CND_ALWAYS,   target: PC_EMIT};
      4'd14: w = '{act: ACT_NOP,       cnd: CND_ALWAYS,   target: PC_FETCH};
      4'd15: w = '{act: ACT_EMIT,      cnd: CND_OUT_BUSY, target: PC_EMIT};
      default: w = '{act: ACT_NOP, cnd: CND_ALWAYS, target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dsts_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module dsts_seq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire dsts_pkg::dsts_flags_t flags,
  output dsts_pkg::dsts_uword_t uword
);
  import dsts_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  // Fetch the current control word
  assign uword = dsts_rom(pc);

  // Evaluate the jump condition
  always_comb begin
    case (uword.cnd)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_IN:    take = !flags.in_valid;
      CND_TICK:     take = flags.is_tick;
      CND_REJECT:   take = flags.reject;
      CND_FREE:     take = flags.is_free;
      CND_H_MORE:   take = flags.h_more;
      CND_SCAN_GO:  take = flags.scan_go;
      CND_HIT:      take = flags.hit;
      CND_OUT_BUSY: take = flags.out_busy;
      default:      take = 1'b0;
    endcase
  end

  // Jump or fall through; the last step wraps to fetch
  assign pc_next = take ? uword.target : pc + PC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // A fetch that takes an item always moves on to dispatch
  a_fetch_leaves: assert property (@(posedge clk) disable iff (rst)
    (uword.act == ACT_ACCEPT && flags.in_valid) |=> (pc == PC_FETCH + PC_W'(1)))
    else $error("sequencer stayed in fetch after a transfer");

endmodule
`default_nettype wire

// File: hdl/daily_section_time_switch.sv
// Top level: daily time switch with schedule, hour counter and section states.
//
//  Channel | Direction | Payload (low bit first)
//  s_*     | in        | tdata: cmd[1:0] section[3:2] on_hour[8:4] off_hour[13:9], zeros above
//  m_*     | out       | tdata: ok[0] hour_now[5:1] section_lit[8:6], zeros above
//
// One item at a time. An add-unique clears the section's column and an add scans hours
// 0..off_hour at most, each by the one-entry-per-cycle walk of the schedule registers.
// A result waits in the output register while the next item is taken; the
// result step holds while that register is still full.
// rst is synchronous: schedule all none, hour 0, all sections off.
`default_nettype none
module daily_section_time_switch (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  // cmd[1:0], section[3:2], on_hour[8:4], off_hour[13:9], zero padding
  input  wire  [dsts_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  // ok[0], hour_now[5:1], section_lit[8:6], zero padding
  output logic [dsts_pkg::OUT_W-1:0] m_tdata
);
  import dsts_pkg::*;

  dsts_uword_t uword;
  dsts_flags_t flags;

  // Latched item fields
  logic [CMD_W-1:0] cmd;
  logic [SEC_W-1:0] sec;
  logic [HR_W-1:0]  on_hr;
  logic [HR_W-1:0]  off_hr;

  // Block state
  sch_row_t              schedule [HOURS];
  logic [HOUR_W-1:0]     hour_count;
  logic [SECTIONS-1:0]   lit_bits;
  logic [HOUR_W-1:0]     h;
  logic                  busy;
  logic                  hit;
  logic                  ok;

  // Datapath combinational signals
  logic                  accept;
  logic                  range_bad;
  logic [HOUR_W-1:0]     rd_addr;
  sch_row_t              rd_row;
  logic [1:0]            col;
  logic                  busy_now;
  logic                  scan_hit;
  logic                  scan_end;
  logic [HOUR_W-1:0]     wr_addr;
  logic                  wr_en;
  logic [1:0]            wr_cmd;
  logic [SECTIONS-1:0]   lit_next;
  logic [3:0]            lit_ext;
  logic                  emit;

  dsts_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uword (uword)
  );

  assign s_tready = (uword.act == ACT_ACCEPT);
  assign accept   = s_tvalid && s_tready;

  // Range check of an add
  always_comb begin
    range_bad = 1'b0;
    if (3'(sec) >= 3'(SECTIONS)) range_bad = 1'b1;
    if (on_hr > HR_W'(HOURS - 1)) range_bad = 1'b1;
    if (off_hr <= on_hr || off_hr > HR_W'(HOURS - 1)) range_bad = 1'b1;
  end

  // Read one schedule row and pick the section column
  assign rd_addr = (uword.act == ACT_APPLY) ? hour_count : h;
  assign rd_row  = schedule[rd_addr];

  always_comb begin
    col = SCH_NONE;
    for (int s = 0; s < SECTIONS; s++) begin
      if (3'(sec) == 3'(s)) col = rd_row[s];
    end
  end

  // Conflict scan of one hour
  assign busy_now = busy || (col == SCH_ON);
  assign scan_hit = (HR_W'(h) >= on_hr) && busy_now;
  assign scan_end = scan_hit || (HR_W'(h) == off_hr);

  // Status for the sequencer
  always_comb begin
    flags.in_valid = s_tvalid;
    flags.is_tick  = (cmd == CMD_TICK);
    flags.reject   = (cmd == CMD_SPARE) || range_bad;
    flags.is_free  = (cmd == CMD_FREE);
    flags.h_more   = (h != HOUR_W'(HOURS - 1));
    flags.scan_go  = !scan_end;
    flags.hit      = hit;
    flags.out_busy = m_tvalid && !m_tready;
  end

  // Schedule write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = h;
    wr_cmd  = SCH_NONE;
    case (uword.act)
      ACT_CLEAR: begin
        wr_en = 1'b1;
      end
      ACT_WRITE_ON: begin
        wr_en   = 1'b1;
        wr_addr = on_hr[HOUR_W-1:0];
        wr_cmd  = SCH_ON;
      end
      ACT_WRITE_OFF: begin
        wr_en   = 1'b1;
        wr_addr = off_hr[HOUR_W-1:0];
        wr_cmd  = SCH_OFF;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HOURS; i++) begin
        schedule[i] <= '0;
      end
    end else if (wr_en) begin
      for (int s = 0; s < SECTIONS; s++) begin
        if (3'(sec) == 3'(s)) schedule[wr_addr][s] <= wr_cmd;
      end
    end
  end

  // Apply one hour's commands to the section states
  always_comb begin
    lit_next = lit_bits;
    for (int s = 0; s < SECTIONS; s++) begin
      if (rd_row[s] == SCH_ON) lit_next[s] = 1'b1;
      else if (rd_row[s] == SCH_OFF) lit_next[s] = 1'b0;
    end
  end

  // Capture the item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= s_tdata[1:0];
      sec    <= s_tdata[3:2];
      on_hr  <= s_tdata[8:4];
      off_hr <= s_tdata[13:9];
    end
  end

  // Hour, section states, scan counter and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count <= '0;
      lit_bits   <= '0;
      h          <= '0;
      busy       <= 1'b0;
      hit        <= 1'b0;
      ok         <= 1'b0;
    end else begin
      case (uword.act)
        ACT_ACCEPT: begin
          if (accept) ok <= 1'b0;
        end
        ACT_H_ZERO: begin
          h <= '0;
        end
        ACT_CLEAR: begin
          h <= h + HOUR_W'(1);
        end
        ACT_WRITE_OFF: begin
          ok <= 1'b1;
        end
        ACT_SCAN_INIT: begin
          h    <= '0;
          busy <= 1'b0;
          hit  <= 1'b0;
        end
        ACT_SCAN_STEP: begin
          hit  <= scan_hit;
          busy <= busy_now && (col != SCH_OFF);
          h    <= h + HOUR_W'(1);
        end
        ACT_HOUR_ADV: begin
          hour_count <= (hour_count == HOUR_W'(HOURS - 1)) ? '0 : hour_count + HOUR_W'(1);
        end
        ACT_APPLY: begin
          lit_bits <= lit_next;
          ok       <= 1'b1;
        end
        default: begin
          ok <= ok;
        end
      endcase
    end
  end

  // Output register
  assign emit    = (uword.act == ACT_EMIT) && !(m_tvalid && !m_tready);
  assign lit_ext = 4'(lit_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {7'd0, lit_ext[LIT_W-1:0], HR_W'(hour_count), ok};
    end
  end

  // The hour never leaves its range
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    hour_count <= HOUR_W'(HOURS - 1))
    else $error("hour counter out of range");

  // Section states change only by applying an hour
  a_lit_apply: assert property (@(posedge clk) disable iff (rst)
    !$stable(lit_bits) |-> ($past(uword.act) == ACT_APPLY || $past(rst)))
    else $error("section states changed outside an apply step");

  // The hour moves only by a tick
  a_hour_tick: assert property (@(posedge clk) disable iff (rst)
    !$stable(hour_count) |-> ($past(uword.act) == ACT_HOUR_ADV || $past(rst)))
    else $error("hour changed outside a tick");

  // A new result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending transfer");

endmodule
`default_nettype wire

// File: test/tb_daily_section_time_switch.sv
// Testbench for the daily section time switch: directed and random items checked against a predictor.
module tb_daily_section_time_switch;
  timeunit 1ns;
  timeprecision 1ps;

  import dsts_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    cmd_t            cmd;
    logic [SEC_W-1:0] section;
    logic [HR_W-1:0]  on_hr;
    logic [HR_W-1:0]  off_hr;
  } item_t;

  typedef struct {
    logic             ok;
    logic [HR_W-1:0]  hour;
    logic [LIT_W-1:0] lit;
  } status_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Predicted switch state
  sch_t                sched [HOURS][SECTIONS];
  int unsigned         hour_cnt;
  logic [SECTIONS-1:0] lit_q;

  item_t   item_q[$];
  status_t status_q[$];

  int      errors = 0;
  int      total_items = 0;
  int      accepted_cnt = 0;
  int      cycles = 0;
  bit      in_fire = 1'b0;
  int      gap_left = 0;
  int      burst_left = 1;
  logic [15:0] stall_pat = 16'hffff;
  int      stall_idx = 0;

  daily_section_time_switch dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic bit range_valid(input item_t it);
    return (it.section < SECTIONS) && (it.on_hr <= HOURS - 1) &&
           (it.off_hr > it.on_hr) && (it.off_hr <= HOURS - 1);
  endfunction

  // Apply one item to the predicted state and return the status it reports
  function automatic status_t apply_item(input item_t it);
    status_t st;
    bit      ok;
    bit      busy;
    bit      stop;
    sch_t    c;
    int      h;
    int      s;
    ok = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        hour_cnt = (hour_cnt + 1) % HOURS;
        for (s = 0; s < SECTIONS; s++) begin
          if (sched[hour_cnt][s] == SCH_ON) lit_q[s] = 1'b1;
          else if (sched[hour_cnt][s] == SCH_OFF) lit_q[s] = 1'b0;
        end
        ok = 1'b1;
      end
      CMD_UNIQUE: begin
        if (range_valid(it)) begin
          for (h = 0; h < HOURS; h++) sched[h][it.section] = SCH_NONE;
          sched[it.on_hr][it.section]  = SCH_ON;
          sched[it.off_hr][it.section] = SCH_OFF;
          ok = 1'b1;
        end
      end
      CMD_FREE: begin
        if (range_valid(it)) begin
          // Walk the column; an activation open at any hour from on_hour to off_hour blocks the add
          busy = 1'b0;
          stop = 1'b0;
          for (h = 0; h <= int'(it.off_hr) && !stop; h++) begin
            c = sched[h][it.section];
            if (c == SCH_ON) busy = 1'b1;
            if (h >= int'(it.on_hr) && busy) stop = 1'b1;
            else if (c == SCH_OFF) busy = 1'b0;
          end
          if (!busy) begin
            sched[it.on_hr][it.section]  = SCH_ON;
            sched[it.off_hr][it.section] = SCH_OFF;
            ok = 1'b1;
          end
        end
      end
      default: ok = 1'b0;
    endcase
    st.ok   = ok;
    st.hour = HR_W'(hour_cnt);
    st.lit  = LIT_W'(lit_q);
    return st;
  endfunction

  task automatic add_item(input cmd_t cmd, input int sec, input int on_h, input int off_h);
    item_t it;
    it.cmd     = cmd;
    it.section = SEC_W'(sec);
    it.on_hr   = HR_W'(on_h);
    it.off_hr  = HR_W'(off_h);
    item_q.push_back(it);
  endtask

  // Drive the input stream in bursts and the output ready on a stall pattern
  always @(negedge clk) begin
    logic            nvalid;
    logic [IN_W-1:0] ndata;
    item_t           it;
    nvalid = s_tvalid;
    ndata  = s_tdata;
    if (rst) begin
      nvalid = 1'b0;
    end else if (!s_tvalid || in_fire) begin
      nvalid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (item_q.size() > 0) begin
        it     = item_q.pop_front();
        nvalid = 1'b1;
        ndata  = {{(IN_W - 14){1'b0}}, it.off_hr, it.on_hr, it.section, it.cmd};
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(3) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(1, 30);
        end
      end
    end
    s_tvalid <= nvalid;
    s_tdata  <= ndata;

    m_tready <= stall_pat[stall_idx];
    if (stall_idx == 15) begin
      stall_idx = 0;
      case ($urandom_range(3))
        0: stall_pat = 16'hffff;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom) | 16'($urandom);
        default: stall_pat = 16'($urandom) & 16'($urandom);
      endcase
    end else begin
      stall_idx++;
    end
  end

  // Check each result transfer, then predict from each input transfer
  always @(posedge clk) begin
    status_t want;
    item_t   it;
    in_fire = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (status_q.size() == 0) begin
        flag_mismatch($sformatf("result 0x%0h with nothing expected", m_tdata));
      end else begin
        want = status_q.pop_front();
        if (m_tdata[0] !== want.ok)
          flag_mismatch($sformatf("ok got %0b want %0b", m_tdata[0], want.ok));
        if (m_tdata[5:1] !== want.hour)
          flag_mismatch($sformatf("hour_now got %0d want %0d", m_tdata[5:1], want.hour));
        if (m_tdata[8:6] !== want.lit)
          flag_mismatch($sformatf("section_lit got %b want %b", m_tdata[8:6], want.lit));
      end
    end
    if (in_fire) begin
      it.cmd     = cmd_t'(s_tdata[1:0]);
      it.section = s_tdata[3:2];
      it.on_hr   = s_tdata[8:4];
      it.off_hr  = s_tdata[13:9];
      status_q.push_back(apply_item(it));
      accepted_cnt++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("daily_section_time_switch verification failed");
      $finish;
    end
  end

  initial begin
    int r;
    int sec;
    int on_h;
    for (int h = 0; h < HOURS; h++)
      for (int s = 0; s < SECTIONS; s++) sched[h][s] = SCH_NONE;
    hour_cnt = 0;
    lit_q    = '0;

    // Directed: ignored fields, spare command, range checks, adjacency
    add_item(CMD_TICK,   3, 31, 31);
    add_item(CMD_SPARE,  0, 0, 0);
    add_item(CMD_SPARE,  3, 31, 31);
    add_item(CMD_UNIQUE, 3, 1, 2);
    add_item(CMD_UNIQUE, 0, 24, 25);
    add_item(CMD_UNIQUE, 0, 5, 5);
    add_item(CMD_UNIQUE, 0, 6, 5);
    add_item(CMD_UNIQUE, 0, 5, 24);
    add_item(CMD_UNIQUE, 0, 0, 23);
    add_item(CMD_UNIQUE, 1, 1, 3);
    add_item(CMD_FREE,   1, 3, 6);
    add_item(CMD_FREE,   1, 4, 6);
    add_item(CMD_FREE,   1, 7, 9);
    add_item(CMD_FREE,   2, 10, 12);
    add_item(CMD_FREE,   2, 8, 10);
    add_item(CMD_FREE,   2, 11, 12);
    add_item(CMD_FREE,   2, 13, 14);
    add_item(CMD_FREE,   3, 1, 2);
    add_item(CMD_FREE,   0, 31, 31);
    add_item(CMD_FREE,   0, 22, 23);
    for (int i = 0; i < 5; i++) add_item(CMD_TICK, 0, 0, 0);

    // Random: mostly well-formed activations between ticks, some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r    = $urandom_range(99);
      sec  = $urandom_range(SECTIONS - 1);
      on_h = $urandom_range(HOURS - 2);
      if (r < 45) begin
        add_item(CMD_TICK, $urandom_range(3), $urandom_range(31), $urandom_range(31));
      end else if (r < 60) begin
        add_item(CMD_UNIQUE, sec, on_h, $urandom_range(on_h + 1, HOURS - 1));
      end else if (r < 88) begin
        add_item(CMD_FREE, sec, on_h,
                 (on_h + 4 > HOURS - 1) ? HOURS - 1 : $urandom_range(on_h + 1, on_h + 4));
      end else begin
        add_item(cmd_t'($urandom_range(3)), $urandom_range(3), $urandom_range(31),
                 $urandom_range(31));
      end
    end
    total_items = item_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every item to be taken and every result to arrive
    while (accepted_cnt != total_items || status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (status_q.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", status_q.size()));

    if (errors == 0) begin
      $display("daily_section_time_switch verification clean");
    end else begin
      $display("daily_section_time_switch verification failed");
    end
    $finish;
  end

endmodule
